[sv/drce_pkg.sv]
// shared types and constants for the rectangle collision extents block
// depends on nothing; imported by every module of the block
package drce_pkg;

	// default sizing, handed down from the top level parameters
	localparam int MAX_RECTS_DEF  = 8;
	localparam int COORD_BITS_DEF = 12;

	// fixed port field widths
	localparam int IN_COORD_W  = 12;
	localparam int OUT_COORD_W = 12;
	localparam int OUT_SPAN_W  = 13;
	localparam int IDX_W       = 3;

	// at most this many results per batch
	localparam int RESULT_LIMIT = 8;
	localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

	// one result word as it leaves the block
	typedef struct packed {
		logic                   overflow;
		logic                   has_extent;
		logic [IDX_W-1:0]       source_index;
		logic [OUT_COORD_W-1:0] ext_x;
		logic [OUT_COORD_W-1:0] ext_y;
		logic [OUT_SPAN_W-1:0]  ext_w;
		logic [OUT_SPAN_W-1:0]  ext_h;
		logic                   last_result;
	} result_t;

endpackage

[sv/drce_rect_mem.sv]
// rectangle store: one write port, one read port, registered read data
// depends on drce_pkg
module drce_rect_mem
	import drce_pkg::*;
#(
	parameter int DEPTH  = MAX_RECTS_DEF,
	parameter int WIDTH  = 4 * COORD_BITS_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and registered read of the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/drce_scan.sv]
// pairwise collision scan over the rectangle store and result output register
// depends on drce_pkg; drives the read port of drce_rect_mem
module drce_scan
	import drce_pkg::*;
#(
	parameter int MAX_RECTS  = MAX_RECTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int AW        = $clog2(MAX_RECTS),
	localparam int CW        = $clog2(MAX_RECTS + 1),
	localparam int CB        = COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	// batch start from the load side
	input  logic          go,
	input  logic [CW-1:0] go_count,
	input  logic          go_dropped,
	output logic          done,
	// store read port
	output logic [AW-1:0] raddr,
	input  logic [4*CB-1:0] rdata,
	// result stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [55:0]   m_axis_tdata, // source_index, ext_x, ext_y, ext_w, ext_h, zero pad
	output logic [1:0]    m_axis_tuser, // has_extent, overflow
	output logic          m_axis_tlast
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD_A  = 6'b000010,
		S_LD_A  = 6'b000100,
		S_CMP   = 6'b001000,
		S_EMIT  = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t state_q;

	logic [AW-1:0]        i_q;
	logic [AW-1:0]        j_q;
	logic [AW-1:0]        last_idx_q;
	logic                 ovf_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 any_q;

	// rectangle i and its running extent
	logic [CB-1:0] ax_q, ay_q;
	logic [CB:0]   ahx_q, ahy_q;
	logic [CB-1:0] lo_x_q, lo_y_q;
	logic [CB:0]   hi_x_q, hi_y_q;

	result_t pend_q;
	logic    pend_vld_q;
	result_t out_q;
	logic    out_vld_q;

	logic          out_free;
	logic          out_load;
	logic [CB-1:0] bx, by, bw, bh;
	logic [CB:0]   bhx, bhy;
	logic [CB-1:0] top;
	logic [CB:0]   bot;
	logic          hit;
	logic          j_last;
	result_t       new_res;
	result_t       null_res;
	result_t       pend_last;

	assign out_free = !out_vld_q || m_axis_tready;

	// a word enters the output register this cycle
	assign out_load = ((state_q == S_EMIT) && any_q && pend_vld_q && out_free)
		|| ((state_q == S_FLUSH) && out_free);

	// split the stored word read back (rectangle i in S_LD_A, rectangle j in S_CMP)
	assign bx  = rdata[CB-1:0];
	assign by  = rdata[2*CB-1:CB];
	assign bw  = rdata[3*CB-1:2*CB];
	assign bh  = rdata[4*CB-1:3*CB];
	assign bhx = {1'b0, bx} + {1'b0, bw};
	assign bhy = {1'b0, by} + {1'b0, bh};

	// collision test of j against i
	assign top = (ay_q > by) ? ay_q : by;
	assign bot = (ahy_q < bhy) ? ahy_q : bhy;
	assign hit = (bx >= ax_q) && ({1'b0, bx} < ahx_q) && ({1'b0, top} < bot)
		&& (j_q != i_q);

	assign j_last = (j_q == last_idx_q);

	// read address follows the scan position
	always_comb begin
		raddr = '0;
		unique case (state_q)
			S_RD_A:  raddr = i_q;
			S_CMP:   raddr = j_last ? '0 : AW'(j_q + 1'b1);
			default: raddr = '0;
		endcase
	end

	// result words for a found extent, the final pending word and an empty batch
	always_comb begin
		new_res              = '0;
		new_res.overflow     = ovf_q;
		new_res.has_extent   = 1'b1;
		new_res.source_index = IDX_W'(i_q);
		new_res.ext_x        = OUT_COORD_W'(lo_x_q);
		new_res.ext_y        = OUT_COORD_W'(lo_y_q);
		new_res.ext_w        = OUT_SPAN_W'(hi_x_q - {1'b0, lo_x_q});
		new_res.ext_h        = OUT_SPAN_W'(hi_y_q - {1'b0, lo_y_q});
		pend_last             = pend_q;
		pend_last.last_result = 1'b1;
		null_res             = '0;
		null_res.overflow    = ovf_q;
		null_res.last_result = 1'b1;
	end

	assign done = (state_q == S_FLUSH) && out_free;

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			last_idx_q <= '0;
			ovf_q      <= 1'b0;
			n_q        <= '0;
			any_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						i_q        <= '0;
						last_idx_q <= AW'(go_count - 1'b1);
						ovf_q      <= go_dropped;
						n_q        <= '0;
						state_q    <= S_RD_A;
					end
				end
				S_RD_A: begin
					state_q <= S_LD_A;
				end
				S_LD_A: begin
					j_q     <= '0;
					any_q   <= 1'b0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						any_q <= 1'b1;
					end
					if (j_last) begin
						state_q <= S_EMIT;
					end else begin
						j_q <= AW'(j_q + 1'b1);
					end
				end
				S_EMIT: begin
					if (!any_q || !pend_vld_q || out_free) begin
						if (any_q) begin
							pend_vld_q <= 1'b1;
							n_q        <= RES_CNT_W'(n_q + 1'b1);
						end
						if ((any_q && (n_q == RES_CNT_W'(RESULT_LIMIT - 1)))
							|| (i_q == last_idx_q)) begin
							state_q <= S_FLUSH;
						end else begin
							i_q     <= AW'(i_q + 1'b1);
							state_q <= S_RD_A;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// extent datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LD_A: begin
				ax_q   <= bx;
				ay_q   <= by;
				ahx_q  <= bhx;
				ahy_q  <= bhy;
				lo_x_q <= bx;
				lo_y_q <= by;
				hi_x_q <= bhx;
				hi_y_q <= bhy;
			end
			S_CMP: begin
				if (hit) begin
					if (bx < lo_x_q) lo_x_q <= bx;
					if (by < lo_y_q) lo_y_q <= by;
					if (bhx > hi_x_q) hi_x_q <= bhx;
					if (bhy > hi_y_q) hi_y_q <= bhy;
				end
			end
			S_EMIT: begin
				if (any_q && (!pend_vld_q || out_free)) begin
					if (pend_vld_q) begin
						out_q <= pend_q;
					end
					pend_q <= new_res;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					if (pend_vld_q) begin
						out_q <= pend_last;
					end else begin
						out_q <= null_res;
					end
				end
			end
			default: ;
		endcase
	end

	// output word
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, out_q.ext_h, out_q.ext_w, out_q.ext_y, out_q.ext_x,
		out_q.source_index};
	assign m_axis_tuser  = {out_q.overflow, out_q.has_extent};
	assign m_axis_tlast  = out_q.last_result;

endmodule

[sv/dirty_rect_collision_extents.sv]
// Loading: one rectangle word per cycle while tready is high, into the next free entry.
// After the batch end word tready stays low while the scan runs over the n stored
// rectangles (read i, load i, n compares, emit), longer while the output holds words back.
// The last result word turns valid as tready returns and may still wait there.
// arst_n clears counts, flags and the sequencer; the store is not cleared.
// Depends on drce_pkg, drce_rect_mem and drce_scan.
module dirty_rect_collision_extents
	import drce_pkg::*;
#(
	parameter int MAX_RECTS  = MAX_RECTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // rect_x, rect_y, rect_w, rect_h
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata, // source_index, ext_x, ext_y, ext_w, ext_h, zero pad
	output logic [1:0]  m_axis_tuser, // has_extent, overflow
	output logic        m_axis_tlast
);

	localparam int AW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int CB = COORD_BITS;

	logic [CW-1:0]   count_q;
	logic            dropped_q;
	logic            busy_q;
	logic            accept;
	logic            store_en;
	logic            go;
	logic [CW-1:0]   go_count;
	logic            go_dropped;
	logic            done;
	logic [4*CB-1:0] wdata;
	logic [AW-1:0]   raddr;
	logic [4*CB-1:0] rdata;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign store_en      = accept && (count_q < CW'(MAX_RECTS));
	assign go            = accept && s_axis_tlast;
	assign go_count      = store_en ? CW'(count_q + 1'b1) : count_q;
	assign go_dropped    = dropped_q || !store_en;

	// coordinates taken modulo the coordinate width
	assign wdata = {CB'(s_axis_tdata[4*IN_COORD_W-1:3*IN_COORD_W]),
		CB'(s_axis_tdata[3*IN_COORD_W-1:2*IN_COORD_W]),
		CB'(s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W]),
		CB'(s_axis_tdata[IN_COORD_W-1:0])};

	// load count, drop flag and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			if (go) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
				busy_q    <= 1'b1;
			end else if (accept) begin
				if (store_en) begin
					count_q <= CW'(count_q + 1'b1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	drce_rect_mem #(
		.DEPTH (MAX_RECTS),
		.WIDTH (4 * CB)
	) u_mem (
		.clk   (clk),
		.we    (store_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	drce_scan #(
		.MAX_RECTS  (MAX_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.go_count      (go_count),
		.go_dropped    (go_dropped),
		.done          (done),
		.raddr         (raddr),
		.rdata         (rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
